// ===== rtl/acs_pkg.sv =====
// Package for the Arabic contextual shaper: types, joining tables and shaping functions.
// Used by acs_shape_core, acs_out_fifo and arabic_contextual_shaper. No dependencies.
`default_nettype none
package acs_pkg;

    localparam int GLYPH_W     = 16;
    localparam int RESULTS_MAX = 3;
    localparam int FIFO_DEPTH  = 8;

    typedef logic [GLYPH_W-1:0] t_code;

    localparam logic [1:0] JOIN_U = 2'd0;
    localparam logic [1:0] JOIN_R = 2'd1;
    localparam logic [1:0] JOIN_D = 2'd3;

    localparam t_code CP_ZWNJ    = 16'h200C;
    localparam t_code CP_ZWJ     = 16'h200D;
    localparam t_code CP_TATWEEL = 16'h0640;
    localparam t_code CP_FA_YEH  = 16'h06CC;
    localparam t_code CP_SPACE   = 16'h0020;

    localparam logic MODE_AR = 1'b0;
    localparam logic MODE_FA = 1'b1;

    typedef enum logic [1:0] {
        GRP_OTHER = 2'd0,
        GRP_ALEF  = 2'd1,
        GRP_LAM   = 2'd2
    } t_group;

    typedef struct packed {
        logic       hit;
        t_code      form;
        logic [1:0] join_cls;
        t_group     grp;
    } t_row;

    typedef struct packed {
        logic  vld;
        logic  last;
        t_code glyph;
    } t_entry;

    typedef struct packed {
        t_entry [RESULTS_MAX-1:0] ent;
    } t_results;

    typedef struct packed {
        logic   emit;
        t_code  emit_glyph;
        t_code  pend_glyph;
        logic   pend_valid;
        t_group grp;
    } t_shape;

    function automatic t_row mk_row(input t_code form, input logic [1:0] jc, input t_group g);
        t_row r;
        r.hit      = 1'b1;
        r.form     = form;
        r.join_cls = jc;
        r.grp      = g;
        return r;
    endfunction

    function automatic t_row lookup_ar(input t_code c);
        t_row r;
        r = '0;
        case (c)
            16'h0621: r = mk_row(16'hFE80, JOIN_U, GRP_OTHER);
            16'h0622: r = mk_row(16'hFE81, JOIN_R, GRP_ALEF);
            16'h0623: r = mk_row(16'hFE83, JOIN_R, GRP_ALEF);
            16'h0624: r = mk_row(16'hFE85, JOIN_R, GRP_OTHER);
            16'h0625: r = mk_row(16'hFE87, JOIN_R, GRP_ALEF);
            16'h0626: r = mk_row(16'hFE89, JOIN_D, GRP_OTHER);
            16'h0627: r = mk_row(16'hFE8D, JOIN_R, GRP_ALEF);
            16'h0628: r = mk_row(16'hFE8F, JOIN_D, GRP_OTHER);
            16'h0629: r = mk_row(16'hFE93, JOIN_R, GRP_OTHER);
            16'h062A: r = mk_row(16'hFE95, JOIN_D, GRP_OTHER);
            16'h062B: r = mk_row(16'hFE99, JOIN_D, GRP_OTHER);
            16'h062C: r = mk_row(16'hFE9D, JOIN_D, GRP_OTHER);
            16'h062D: r = mk_row(16'hFEA1, JOIN_D, GRP_OTHER);
            16'h062E: r = mk_row(16'hFEA5, JOIN_D, GRP_OTHER);
            16'h062F: r = mk_row(16'hFEA9, JOIN_R, GRP_OTHER);
            16'h0630: r = mk_row(16'hFEAB, JOIN_R, GRP_OTHER);
            16'h0631: r = mk_row(16'hFEAD, JOIN_R, GRP_OTHER);
            16'h0632: r = mk_row(16'hFEAF, JOIN_R, GRP_OTHER);
            16'h0633: r = mk_row(16'hFEB1, JOIN_D, GRP_OTHER);
            16'h0634: r = mk_row(16'hFEB5, JOIN_D, GRP_OTHER);
            16'h0635: r = mk_row(16'hFEB9, JOIN_D, GRP_OTHER);
            16'h0636: r = mk_row(16'hFEBD, JOIN_D, GRP_OTHER);
            16'h0637: r = mk_row(16'hFEC1, JOIN_D, GRP_OTHER);
            16'h0638: r = mk_row(16'hFEC5, JOIN_D, GRP_OTHER);
            16'h0639: r = mk_row(16'hFEC9, JOIN_D, GRP_OTHER);
            16'h063A: r = mk_row(16'hFECD, JOIN_D, GRP_OTHER);
            16'h0640: r = mk_row(16'h0640, JOIN_D, GRP_OTHER);
            16'h0641: r = mk_row(16'hFED1, JOIN_D, GRP_OTHER);
            16'h0642: r = mk_row(16'hFED5, JOIN_D, GRP_OTHER);
            16'h0643: r = mk_row(16'hFED9, JOIN_D, GRP_OTHER);
            16'h0644: r = mk_row(16'hFEDD, JOIN_D, GRP_LAM);
            16'h0645: r = mk_row(16'hFEE1, JOIN_D, GRP_OTHER);
            16'h0646: r = mk_row(16'hFEE5, JOIN_D, GRP_OTHER);
            16'h0647: r = mk_row(16'hFEE9, JOIN_D, GRP_OTHER);
            16'h0648: r = mk_row(16'hFEED, JOIN_R, GRP_OTHER);
            16'h0649: r = mk_row(16'hFEEF, JOIN_D, GRP_OTHER);
            16'h064A: r = mk_row(16'hFEF1, JOIN_D, GRP_OTHER);
            16'h067E: r = mk_row(16'hFB56, JOIN_D, GRP_OTHER);
            16'h0686: r = mk_row(16'hFB7A, JOIN_D, GRP_OTHER);
            16'h06A9: r = mk_row(16'hFB8E, JOIN_D, GRP_OTHER);
            16'h06AF: r = mk_row(16'hFB92, JOIN_D, GRP_OTHER);
            16'h06CA: r = mk_row(16'hFED5, JOIN_D, GRP_OTHER);
            16'h06CC: r = mk_row(16'hFBFC, JOIN_D, GRP_OTHER);
            16'h200C: r = mk_row(16'h200C, JOIN_U, GRP_OTHER);
            16'h200D: r = mk_row(16'h200D, JOIN_D, GRP_OTHER);
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic t_row lookup_fa(input t_code c);
        t_row r;
        r = '0;
        case (c)
            16'h0627: r = mk_row(16'hFE8D, JOIN_R, GRP_ALEF);
            16'h0628: r = mk_row(16'hFE8F, JOIN_D, GRP_OTHER);
            16'h067E: r = mk_row(16'hFB56, JOIN_D, GRP_OTHER);
            16'h062A: r = mk_row(16'hFE95, JOIN_D, GRP_OTHER);
            16'h062B: r = mk_row(16'hFE99, JOIN_D, GRP_OTHER);
            16'h062C: r = mk_row(16'hFE9D, JOIN_D, GRP_OTHER);
            16'h0686: r = mk_row(16'hFB7A, JOIN_D, GRP_OTHER);
            16'h062D: r = mk_row(16'hFEA1, JOIN_D, GRP_OTHER);
            16'h062E: r = mk_row(16'hFEA5, JOIN_D, GRP_OTHER);
            16'h062F: r = mk_row(16'hFEA9, JOIN_R, GRP_OTHER);
            16'h0630: r = mk_row(16'hFEAB, JOIN_R, GRP_OTHER);
            16'h0631: r = mk_row(16'hFEAD, JOIN_R, GRP_OTHER);
            16'h0632: r = mk_row(16'hFEAF, JOIN_R, GRP_OTHER);
            16'h0698: r = mk_row(16'hFB8A, JOIN_R, GRP_OTHER);
            16'h0633: r = mk_row(16'hFEB1, JOIN_D, GRP_OTHER);
            16'h0634: r = mk_row(16'hFEB5, JOIN_D, GRP_OTHER);
            16'h0635: r = mk_row(16'hFEB9, JOIN_D, GRP_OTHER);
            16'h0636: r = mk_row(16'hFEBD, JOIN_D, GRP_OTHER);
            16'h0637: r = mk_row(16'hFEC1, JOIN_D, GRP_OTHER);
            16'h0638: r = mk_row(16'hFEC5, JOIN_D, GRP_OTHER);
            16'h0639: r = mk_row(16'hFEC9, JOIN_D, GRP_OTHER);
            16'h063A: r = mk_row(16'hFECD, JOIN_D, GRP_OTHER);
            16'h0641: r = mk_row(16'hFED1, JOIN_D, GRP_OTHER);
            16'h0642: r = mk_row(16'hFED5, JOIN_D, GRP_OTHER);
            16'h06A9: r = mk_row(16'hFB8E, JOIN_D, GRP_OTHER);
            16'h06AF: r = mk_row(16'hFB92, JOIN_D, GRP_OTHER);
            16'h0644: r = mk_row(16'hFEDD, JOIN_D, GRP_LAM);
            16'h0645: r = mk_row(16'hFEE1, JOIN_D, GRP_OTHER);
            16'h0646: r = mk_row(16'hFEE5, JOIN_D, GRP_OTHER);
            16'h0648: r = mk_row(16'hFEED, JOIN_R, GRP_OTHER);
            16'h0647: r = mk_row(16'hFEE9, JOIN_D, GRP_OTHER);
            16'h06CC: r = mk_row(16'hFEEF, JOIN_D, GRP_OTHER);
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic t_row lookup(input t_code c, input logic mode);
        return (mode == MODE_FA) ? lookup_fa(c) : lookup_ar(c);
    endfunction

    function automatic t_code ligature_of(input t_code g);
        t_code l;
        case (g)
            16'hFE82: l = 16'hFEF5;
            16'hFE84: l = 16'hFEF7;
            16'hFE88: l = 16'hFEF9;
            16'hFE8E: l = 16'hFEFB;
            default:  l = CP_SPACE;
        endcase
        return l;
    endfunction

    // Shape one held unit against the pending glyph register.
    function automatic t_shape shape(input t_code code, input logic [1:0] form_bits,
                                     input logic mode, input t_group prev,
                                     input t_code pend, input logic pend_vld);
        t_shape     s;
        t_row       r;
        logic [2:0] off;
        t_code      g;
        s.emit       = 1'b0;
        s.emit_glyph = pend;
        s.pend_glyph = pend;
        s.pend_valid = pend_vld;
        s.grp        = prev;
        r   = lookup(code, mode);
        off = {1'b0, form_bits};
        if (mode == MODE_FA && code == CP_FA_YEH && form_bits > 2'd1) begin
            off = off + 3'd2;
        end
        g = (code == CP_TATWEEL) ? CP_TATWEEL : t_code'(r.form + {13'd0, off});
        if (code != '0) begin
            if (!r.hit) begin
                s.emit       = pend_vld;
                s.pend_glyph = code;
                s.pend_valid = 1'b1;
                s.grp        = GRP_OTHER;
            end else begin
                if (r.grp == GRP_LAM && prev == GRP_ALEF) begin
                    s.pend_glyph = t_code'(ligature_of(pend) + {15'd0, off[0]});
                    s.pend_valid = 1'b1;
                end else if (r.form != CP_ZWNJ && r.form != CP_ZWJ) begin
                    s.emit       = pend_vld;
                    s.pend_glyph = g;
                    s.pend_valid = 1'b1;
                end
                s.grp = r.grp;
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/arabic_contextual_shaper.sv =====
// Top level of the Arabic/Persian contextual shaper: shaping core plus result queue.
// Depends on acs_pkg, acs_shape_core and acs_out_fifo.
//
// Takes one code unit per cycle while o_in_ready is high, last code unit of a segment first,
// and emits shaped glyphs in visual order, one result beat per cycle while i_out_ready is
// high. Each glyph leaves two code units late: a unit is held until its neighbor is known,
// then waits in a one-glyph pending register so a lam can fold the preceding alef into a
// ligature. The segment-end unit flushes up to three glyphs at once into a small queue;
// input is taken whenever the queue has room for three entries, so with a steady output
// sink the block sustains one code unit per cycle. The user must write the language
// register with i_cfg_we only while the block is idle; the block does not enforce this.
`default_nettype none
module arabic_contextual_shaper #(
    parameter int P_FIFO_DEPTH = acs_pkg::FIFO_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire acs_pkg::t_code i_code_point,
    input  wire logic           i_segment_end,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output acs_pkg::t_code      o_glyph,
    output logic                o_last_glyph
);
    import acs_pkg::*;

    t_results res;
    logic     beat;

    assign beat = i_in_valid && o_in_ready;

    acs_shape_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_beat        (beat),
        .i_code_point  (i_code_point),
        .i_segment_end (i_segment_end),
        .o_res         (res)
    );

    acs_out_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_glyph (o_glyph),
        .o_last  (o_last_glyph)
    );

endmodule
`default_nettype wire

// ===== rtl/acs_shape_core.sv =====
// Shaping core: language register, held unit, joining context and pending glyph.
// Produces up to three result entries per input beat. Depends on acs_pkg.
`default_nettype none
module acs_shape_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    input  wire logic              i_beat,
    input  wire acs_pkg::t_code    i_code_point,
    input  wire logic              i_segment_end,
    output acs_pkg::t_results      o_res
);
    import acs_pkg::*;

    logic       r_mode;
    t_code      r_held_code;
    logic [1:0] r_held_join;
    logic [1:0] r_held_form;
    t_group     r_prev_group;
    t_code      r_pend_glyph;
    logic       r_pend_valid;

    t_row       row_c;
    logic       links;
    logic [1:0] held_form;
    logic [1:0] new_form;
    t_shape     s0;
    t_shape     s1;

    always_comb begin
        row_c     = lookup(i_code_point, r_mode);
        links     = r_held_join[0] && row_c.join_cls[1];
        held_form = links ? (r_held_form | 2'b01) : r_held_form;
        new_form  = links ? 2'd2 : 2'd0;
        s0 = shape(r_held_code, held_form, r_mode, r_prev_group, r_pend_glyph, r_pend_valid);
        s1 = shape(i_code_point, new_form, r_mode, s0.grp, s0.pend_glyph, s0.pend_valid);
        o_res.ent[0].vld   = i_beat && s0.emit;
        o_res.ent[0].last  = 1'b0;
        o_res.ent[0].glyph = s0.emit_glyph;
        o_res.ent[1].vld   = i_beat && i_segment_end && s1.emit;
        o_res.ent[1].last  = 1'b0;
        o_res.ent[1].glyph = s1.emit_glyph;
        o_res.ent[2].vld   = i_beat && i_segment_end && s1.pend_valid;
        o_res.ent[2].last  = 1'b1;
        o_res.ent[2].glyph = s1.pend_glyph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_AR;
            r_held_code  <= '0;
            r_held_join  <= JOIN_U;
            r_held_form  <= '0;
            r_prev_group <= GRP_OTHER;
            r_pend_glyph <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_beat) begin
                if (i_segment_end) begin
                    r_held_code  <= '0;
                    r_held_join  <= JOIN_U;
                    r_held_form  <= '0;
                    r_prev_group <= GRP_OTHER;
                    r_pend_glyph <= '0;
                    r_pend_valid <= 1'b0;
                end else begin
                    r_held_code  <= i_code_point;
                    r_held_join  <= row_c.join_cls;
                    r_held_form  <= new_form;
                    r_prev_group <= s0.grp;
                    r_pend_glyph <= s0.pend_glyph;
                    r_pend_valid <= s0.pend_valid;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/acs_out_fifo.sv =====
// Result queue: takes up to three entries per beat in order, delivers one beat per cycle while i_ready is high.
// DEPTH must be a power of two. Depends on acs_pkg.
`default_nettype none
module acs_out_fifo #(
    parameter int DEPTH = acs_pkg::FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acs_pkg::t_results i_res,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output acs_pkg::t_code         o_glyph,
    output logic                   o_last
);
    import acs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] wa [RESULTS_MAX];
    logic [1:0]       n_push;
    logic             pop;

    always_comb begin
        n_push = 2'd0;
        for (int k = 0; k < RESULTS_MAX; k++) begin
            wa[k] = r_wr + PTR_W'(n_push);
            if (i_res.ent[k].vld) begin
                n_push = n_push + 2'd1;
            end
        end
    end

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_W'(DEPTH - RESULTS_MAX));
    assign o_glyph = r_mem[r_rd].glyph;
    assign o_last  = r_mem[r_rd].last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RESULTS_MAX; k++) begin
            if (i_res.ent[k].vld) begin
                r_mem[wa[k]] <= i_res.ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(n_push);
            r_rd    <= pop ? r_rd + PTR_W'(1) : r_rd;
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

endmodule
`default_nettype wire
